/* src/b32enc_pkg.sv */
// Shared types, constants and helpers of the Bech32 string encoder.
`default_nettype none

package b32enc_pkg;

   // Default depth of the readable-part store.
   localparam int MAX_PREFIX_DEF = 16;

   localparam int CSUM_W = 30;

   // BCH generator terms, one for each bit of the checksum's top symbol.
   localparam logic [CSUM_W-1:0] GEN [5] = '{
      30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
   };

   // Symbol alphabet, symbol 0 in the top byte.
   localparam logic [255:0] ALPHABET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

   localparam logic [7:0] SEPARATOR = "1";

   // Request kinds carried on req_tuser.
   typedef enum logic [1:0] {
      FUNC_CHAR   = 2'd0,
      FUNC_DATA   = 2'd1,
      FUNC_FINISH = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   // Operations of the checksum unit.
   typedef enum logic [1:0] {
      CS_HOLD  = 2'd0,
      CS_INIT  = 2'd1,
      CS_FEED  = 2'd2,
      CS_SHIFT = 2'd3
   } csum_op_type;

   typedef struct packed {
      csum_op_type op;
      logic [4:0]  sym;
   } csum_cmd_type;

   function automatic logic [7:0] sym_char(input logic [4:0] sym);
      return ALPHABET[8 * (31 - int'(sym)) +: 8];
   endfunction

endpackage : b32enc_pkg

`default_nettype wire

/* src/b32enc_polymod.sv */
// Shared BCH checksum unit: one 5-bit symbol step, init or symbol shift per cycle.
`default_nettype none

module b32enc_polymod (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire b32enc_pkg::csum_cmd_type        cmd,
   output logic [b32enc_pkg::CSUM_W-1:0]        csum
);

   logic [b32enc_pkg::CSUM_W-1:0] csum_ff;
   logic [b32enc_pkg::CSUM_W-1:0] csum_in;
   logic [b32enc_pkg::CSUM_W-1:0] fed;
   logic [4:0]                    top;

   always_comb begin
      top = csum_ff[29:25];
      fed = {csum_ff[24:0], 5'd0} ^ {25'd0, cmd.sym};
      for (int j = 0; j < 5; j++) begin
         if (top[j]) begin
            fed = fed ^ b32enc_pkg::GEN[j];
         end
      end
      case (cmd.op)
         b32enc_pkg::CS_HOLD:  csum_in = csum_ff;
         b32enc_pkg::CS_INIT:  csum_in = 30'd1;
         b32enc_pkg::CS_FEED:  csum_in = fed;
         b32enc_pkg::CS_SHIFT: csum_in = {csum_ff[24:0], 5'd0};
         default:              csum_in = csum_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csum_ff <= 30'd1;
      end else begin
         csum_ff <= csum_in;
      end
   end

   assign csum = csum_ff;

endmodule : b32enc_polymod

`default_nettype wire

/* src/bech32_string_encoder_unit.sv */
// Top level of the Bech32 string encoder: sequencer, readable-part store, output register.
//
// Usage: each request on the req_ channel carries a kind on req_tuser (readable-part
// character, data byte, finish) and a byte on req_tdata. The rsp_ channel streams the
// encoded string one ASCII character per response; rsp_tlast marks the final checksum
// character and rsp_tuser flags a readable-part character dropped for a full store.
// The block takes one request at a time: req_tready is high only in the idle state.
// Steps per request, run by the sequencer that drives the single checksum unit one
// symbol per cycle unless an emitting step waits on the output register:
//   readable-part character   checksum step on the top three bits, echo, store
//   data byte                 load, then symbols emitted (1 or 2)
//   first data byte / finish  adds zero step, stored readable-part characters (store walk), separator
//   finish                    pad, six zero steps, six checksum characters
// An emitting step waits while the output register holds an untaken response, so a
// stalled receiver simply stretches the request; nothing is lost or repeated.
// Reset (synchronous) returns to the readable-part phase with an empty store, the
// checksum at one and no response pending. Store contents are not cleared; only
// entries below the count are ever read. Finish also restores the phase, the empty store and the checksum.
`default_nettype none

module bech32_string_encoder_unit #(
   parameter int MAX_PREFIX = b32enc_pkg::MAX_PREFIX_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] value
   input  wire logic [1:0] req_tuser,   // [1:0] func
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] character
   output logic            rsp_tlast,   // last
   output logic            rsp_tuser    // [0] error
);

   localparam int CNT_W = $clog2(MAX_PREFIX + 1);
   localparam int IDX_W = (MAX_PREFIX > 1) ? $clog2(MAX_PREFIX) : 1;

   typedef enum logic [9:0] {
      S_IDLE     = 10'b00_0000_0001,
      S_DISPATCH = 10'b00_0000_0010,
      S_PFX_ZERO = 10'b00_0000_0100,
      S_PFX_WALK = 10'b00_0000_1000,
      S_SEP      = 10'b00_0001_0000,
      S_LOAD     = 10'b00_0010_0000,
      S_SYM      = 10'b00_0100_0000,
      S_PAD      = 10'b00_1000_0000,
      S_ZEROS    = 10'b01_0000_0000,
      S_CSUM     = 10'b10_0000_0000
   } state_type;

   state_type                  state_ff, state_in;
   b32enc_pkg::func_type       func_ff, func_in;
   logic [7:0]                 value_ff, value_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [CNT_W-1:0]           walk_ff, walk_in;
   logic [11:0]                acc_ff, acc_in;
   logic [3:0]                 bc_ff, bc_in;
   logic                       phase_ff, phase_in;
   logic [2:0]                 step_ff, step_in;

   // readable-part store
   logic [7:0]                 mem_ff [MAX_PREFIX];
   logic [7:0]                 rd_data_ff;
   logic                       mem_wr;

   // output register
   logic                       out_vld_ff, out_vld_in;
   logic [7:0]                 out_char_ff;
   logic                       out_last_ff;
   logic                       out_err_ff;

   logic                       emit_req, can_emit, emit_fire;
   logic [7:0]                 emit_char;
   logic                       emit_last, emit_err;

   b32enc_pkg::csum_cmd_type   cmd;
   logic [b32enc_pkg::CSUM_W-1:0] csum;

   logic [4:0]                 data_sym;
   logic [16:0]                pad_w;
   logic [4:0]                 out_sym;

   b32enc_polymod u_polymod (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .csum  (csum)
   );

   assign can_emit  = !out_vld_ff || rsp_tready;
   assign emit_fire = emit_req && can_emit;
   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      data_sym = 5'(acc_ff >> (bc_ff - 4'd5));
      pad_w    = {5'd0, acc_ff} << (4'd5 - bc_ff);
      out_sym  = csum[29:25] ^ {4'd0, (step_ff == 3'd5)};
   end

   always_comb begin
      state_in  = state_ff;
      func_in   = func_ff;
      value_in  = value_ff;
      count_in  = count_ff;
      walk_in   = walk_ff;
      acc_in    = acc_ff;
      bc_in     = bc_ff;
      phase_in  = phase_ff;
      step_in   = step_ff;
      mem_wr    = 1'b0;
      emit_req  = 1'b0;
      emit_char = 8'd0;
      emit_last = 1'b0;
      emit_err  = 1'b0;
      cmd.op    = b32enc_pkg::CS_HOLD;
      cmd.sym   = 5'd0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               func_in  = b32enc_pkg::func_type'(req_tuser);
               value_in = req_tdata;
               walk_in  = '0;
               state_in = S_DISPATCH;
            end
         end

         S_DISPATCH: begin
            case (func_ff)
               b32enc_pkg::FUNC_CHAR: begin
                  if (phase_ff) begin
                     state_in = S_IDLE;
                  end else if (count_ff == CNT_W'(MAX_PREFIX)) begin
                     // store full: flag and drop
                     emit_req = 1'b1;
                     emit_err = 1'b1;
                     if (can_emit) state_in = S_IDLE;
                  end else begin
                     emit_req  = 1'b1;
                     emit_char = value_ff;
                     if (can_emit) begin
                        mem_wr   = 1'b1;
                        count_in = count_ff + 1'b1;
                        cmd.op   = b32enc_pkg::CS_FEED;
                        cmd.sym  = {2'd0, value_ff[7:5]};
                        state_in = S_IDLE;
                     end
                  end
               end
               b32enc_pkg::FUNC_DATA: begin
                  state_in = phase_ff ? S_LOAD : S_PFX_ZERO;
               end
               b32enc_pkg::FUNC_FINISH: begin
                  state_in = phase_ff ? S_PAD : S_PFX_ZERO;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end

         S_PFX_ZERO: begin
            cmd.op   = b32enc_pkg::CS_FEED;
            walk_in  = '0;
            state_in = (count_ff == '0) ? S_SEP : S_PFX_WALK;
         end

         S_PFX_WALK: begin
            cmd.op  = b32enc_pkg::CS_FEED;
            cmd.sym = rd_data_ff[4:0];
            walk_in = walk_ff + 1'b1;
            if (walk_in == count_ff) state_in = S_SEP;
         end

         S_SEP: begin
            emit_req  = 1'b1;
            emit_char = b32enc_pkg::SEPARATOR;
            if (can_emit) begin
               phase_in = 1'b1;
               state_in = (func_ff == b32enc_pkg::FUNC_DATA) ? S_LOAD : S_PAD;
            end
         end

         S_LOAD: begin
            acc_in   = {acc_ff[3:0], value_ff};
            bc_in    = bc_ff + 4'd8;
            state_in = S_SYM;
         end

         S_SYM: begin
            if (bc_ff >= 4'd5) begin
               emit_req  = 1'b1;
               emit_char = b32enc_pkg::sym_char(data_sym);
               if (can_emit) begin
                  cmd.op  = b32enc_pkg::CS_FEED;
                  cmd.sym = data_sym;
                  bc_in   = bc_ff - 4'd5;
               end
            end else begin
               state_in = S_IDLE;
            end
         end

         S_PAD: begin
            step_in = '0;
            if (bc_ff != 4'd0) begin
               emit_req  = 1'b1;
               emit_char = b32enc_pkg::sym_char(pad_w[4:0]);
               if (can_emit) begin
                  cmd.op   = b32enc_pkg::CS_FEED;
                  cmd.sym  = pad_w[4:0];
                  state_in = S_ZEROS;
               end
            end else begin
               state_in = S_ZEROS;
            end
         end

         S_ZEROS: begin
            cmd.op  = b32enc_pkg::CS_FEED;
            step_in = step_ff + 1'b1;
            if (step_ff == 3'd5) begin
               step_in  = '0;
               state_in = S_CSUM;
            end
         end

         S_CSUM: begin
            // top symbol out, then shift; final xor with one lands in the last symbol
            emit_req  = 1'b1;
            emit_char = b32enc_pkg::sym_char(out_sym);
            emit_last = (step_ff == 3'd5);
            if (can_emit) begin
               cmd.op  = b32enc_pkg::CS_SHIFT;
               step_in = step_ff + 1'b1;
               if (step_ff == 3'd5) begin
                  cmd.op   = b32enc_pkg::CS_INIT;
                  count_in = '0;
                  acc_in   = '0;
                  bc_in    = '0;
                  phase_in = 1'b0;
                  step_in  = '0;
                  state_in = S_IDLE;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      out_vld_in = emit_fire ? 1'b1 : (rsp_tready ? 1'b0 : out_vld_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         acc_ff     <= '0;
         bc_ff      <= '0;
         phase_ff   <= 1'b0;
         step_ff    <= '0;
         walk_ff    <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         acc_ff     <= acc_in;
         bc_ff      <= bc_in;
         phase_ff   <= phase_in;
         step_ff    <= step_in;
         walk_ff    <= walk_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff  <= func_in;
      value_ff <= value_in;
      if (emit_fire) begin
         out_char_ff <= emit_char;
         out_last_ff <= emit_last;
         out_err_ff  <= emit_err;
      end
   end

   // store: one write port, one registered read port addressed by the walk counter
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         mem_ff[count_ff[IDX_W-1:0]] <= value_ff;
      end
      rd_data_ff <= mem_ff[walk_in[IDX_W-1:0]];
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_char_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_err_ff;

endmodule : bech32_string_encoder_unit

`default_nettype wire

/* src/b32enc_checker.sv */
// Port-level checker for the Bech32 string encoder and its bind.
`default_nettype none

module b32enc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tvalid,
   input wire logic       req_tready,
   input wire logic [1:0] req_tuser,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic       rsp_tlast,
   input wire logic       rsp_tuser
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // a dropped character carries a zero code
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 8'd0 && !rsp_tlast)
      else $error("error response with data");

   // the unit is busy right after taking a request
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // reset leaves no response pending
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response pending after reset");

   // the unit is still busy after dispatching a finish request
   a_finish: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == b32enc_pkg::FUNC_FINISH |=> ##1 !req_tready)
      else $error("finish completed too early");

endmodule : b32enc_checker

bind bech32_string_encoder_unit b32enc_checker u_b32enc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

/* test/tb.sv */
// Self-checking testbench for the Bech32 string encoder: directed and random strings against a local predictor.
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PREFIX_DEPTH = b32enc_pkg::MAX_PREFIX_DEF;

   // One character of the encoded output string.
   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      logic       err;
   } str_char_type;

   // Predicts the encoded string and checks the response stream against it.
   class bech32_scoreboard;
      localparam logic [29:0] POLY [5] = '{
         30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
      };

      string        charset = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";
      logic [7:0]   hrp_mem [PREFIX_DEPTH];
      int unsigned  hrp_len;
      logic [29:0]  crc;
      logic [11:0]  bit_acc;
      int unsigned  bit_cnt;
      bit           data_phase;
      str_char_type expected_chars [$];
      int           errors;

      function new();
         errors = 0;
         clear_string();
      endfunction

      function void clear_string();
         hrp_len    = 0;
         crc        = 30'd1;
         bit_acc    = '0;
         bit_cnt    = 0;
         data_phase = 1'b0;
      endfunction

      function int pending();
         return expected_chars.size();
      endfunction

      function void add_char(logic [7:0] ch, logic last, logic err);
         str_char_type c;
         c.ch   = ch;
         c.last = last;
         c.err  = err;
         expected_chars.push_back(c);
      endfunction

      // One step of the BCH polymod.
      function void crc_step(logic [4:0] sym);
         logic [4:0] top;
         top = crc[29:25];
         crc = {crc[24:0], 5'd0} ^ {25'd0, sym};
         for (int j = 0; j < 5; j++) begin
            if (top[j]) crc = crc ^ POLY[j];
         end
      endfunction

      function void add_symbol(logic [4:0] sym);
         crc_step(sym);
         add_char(charset[sym], 1'b0, 1'b0);
      endfunction

      // Readable part ends: zero separator symbol, low five bits of each stored char.
      function void close_readable();
         if (data_phase) return;
         crc_step(5'd0);
         for (int i = 0; i < hrp_len; i++) crc_step(hrp_mem[i][4:0]);
         data_phase = 1'b1;
         add_char("1", 1'b0, 1'b0);
      endfunction

      function void note_request(b32enc_pkg::func_type f, logic [7:0] v);
         logic [11:0] bits;
         case (f)
            b32enc_pkg::FUNC_CHAR: begin
               if (!data_phase) begin
                  if (hrp_len >= PREFIX_DEPTH) begin
                     add_char(8'd0, 1'b0, 1'b1);
                  end else begin
                     hrp_mem[hrp_len] = v;
                     hrp_len++;
                     crc_step({2'd0, v[7:5]});
                     add_char(v, 1'b0, 1'b0);
                  end
               end
            end
            b32enc_pkg::FUNC_DATA: begin
               close_readable();
               bit_acc = {bit_acc[3:0], v};
               bit_cnt += 8;
               while (bit_cnt >= 5) begin
                  bit_cnt -= 5;
                  bits = bit_acc >> bit_cnt;
                  add_symbol(bits[4:0]);
               end
            end
            b32enc_pkg::FUNC_FINISH: begin
               close_readable();
               if (bit_cnt > 0) begin
                  bits = bit_acc << (5 - bit_cnt);
                  add_symbol(bits[4:0]);
               end
               for (int i = 0; i < 6; i++) crc_step(5'd0);
               crc = crc ^ 30'd1;
               for (int i = 0; i < 6; i++) begin
                  add_char(charset[crc[5 * (5 - i) +: 5]], i == 5, 1'b0);
               end
               clear_string();
            end
            default: ;
         endcase
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_response(logic [7:0] ch, logic last, logic err);
         str_char_type want;
         if (expected_chars.size() == 0) begin
            report($sformatf("unexpected char %02h last %0b err %0b", ch, last, err));
            return;
         end
         want = expected_chars.pop_front();
         if (ch !== want.ch)
            report($sformatf("char %02h, predicted %02h", ch, want.ch));
         if (last !== want.last)
            report($sformatf("last %0b, predicted %0b", last, want.last));
         if (err !== want.err)
            report($sformatf("error flag %0b, predicted %0b", err, want.err));
      endtask
   endclass

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;    // [7:0] value
   logic [1:0] req_tuser;    // [1:0] func
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;    // [7:0] character
   logic       rsp_tlast;
   logic       rsp_tuser;    // [0] error

   bech32_scoreboard sb;

   // Idle rates in percent, changed per stimulus phase.
   int send_idle_pct;
   int recv_idle_pct;
   int items_sent;

   bech32_string_encoder_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop; far beyond the slowest legal run.
   initial begin
      #3_000_000;
      $display("tb failed");
      $finish;
   end

   // Receiver: ready changes only on the falling edge.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Response monitor: sample on the rising edge, values from before the edge.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tdata, rsp_tlast, rsp_tuser);
   end

   // Drive one request; entered and left at a falling edge. Valid stays high
   // into the next request unless the sender decides to idle.
   task send_req(b32enc_pkg::func_type f, logic [7:0] v);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      req_tuser  <= f;
      do @(posedge clock); while (!req_tready);
      sb.note_request(f, v);
      @(negedge clock);
   endtask

   // Hold off until the response stream has fully drained.
   task drain_responses();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);
   endtask

   // One string: readable part, data bytes, finish. Noise requests (unused
   // func code, readable chars after the data phase starts) are not counted.
   task send_string(int n_chars, int n_bytes, bit noisy);
      for (int i = 0; i < n_chars; i++) begin
         send_req(b32enc_pkg::FUNC_CHAR, 8'($urandom_range(255)));
         items_sent++;
         if (noisy && $urandom_range(3) == 0)
            send_req(b32enc_pkg::FUNC_NONE, 8'($urandom_range(255)));
      end
      for (int i = 0; i < n_bytes; i++) begin
         send_req(b32enc_pkg::FUNC_DATA, 8'($urandom_range(255)));
         items_sent++;
         if (noisy && $urandom_range(2) == 0)
            send_req($urandom_range(1) ? b32enc_pkg::FUNC_CHAR : b32enc_pkg::FUNC_NONE,
                     8'($urandom_range(255)));
      end
      send_req(b32enc_pkg::FUNC_FINISH, 8'($urandom_range(255)));
      items_sent++;
   endtask

   initial begin
      int n_chars;
      int n_bytes;
      sb = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = b32enc_pkg::FUNC_NONE;
      send_idle_pct = 7;
      recv_idle_pct = 65;
      items_sent    = 0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // --- directed part ---
      // empty readable part, empty data: separator plus checksum only
      send_req(b32enc_pkg::FUNC_FINISH, 8'h00);
      // extreme char codes, extreme data bytes, ignored requests mid-string
      send_req(b32enc_pkg::FUNC_CHAR, 8'h00);
      send_req(b32enc_pkg::FUNC_CHAR, 8'hff);
      send_req(b32enc_pkg::FUNC_NONE, 8'h55);
      send_req(b32enc_pkg::FUNC_DATA, 8'h00);
      send_req(b32enc_pkg::FUNC_DATA, 8'hff);
      send_req(b32enc_pkg::FUNC_CHAR, 8'h62);   // data phase: dropped silently
      send_req(b32enc_pkg::FUNC_FINISH, 8'hff);
      drain_responses();
      // store full: the 17th readable char is flagged and not stored
      for (int i = 0; i <= PREFIX_DEPTH; i++)
         send_req(b32enc_pkg::FUNC_CHAR, 8'h61 + 8'(i));
      send_req(b32enc_pkg::FUNC_DATA, 8'ha5);
      send_req(b32enc_pkg::FUNC_FINISH, 8'h5a);

      // --- random part, three idle profiles ---
      items_sent = 0;
      while (items_sent < 130) begin
         if (items_sent < 43) begin
            send_idle_pct = 7;
            recv_idle_pct = 65;
         end else if (items_sent < 87) begin
            send_idle_pct = 65;
            recv_idle_pct = 7;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         // mostly short readable parts; now and then a full or overflowing store
         if ($urandom_range(5) == 0) n_chars = $urandom_range(PREFIX_DEPTH + 2, PREFIX_DEPTH - 1);
         else                        n_chars = $urandom_range(6);
         n_bytes = $urandom_range(9);
         send_string(n_chars, n_bytes, $urandom_range(5) == 0);
         if ($urandom_range(3) == 0) drain_responses();
      end

      // --- wind-down ---
      drain_responses();
      repeat (40) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule : tb

`default_nettype wire

/* sim.f */
src/b32enc_pkg.sv
src/b32enc_polymod.sv
src/bech32_string_encoder_unit.sv
src/b32enc_checker.sv
test/tb.sv
